// ----- rtl/deq_pkg.sv -----
// Shared types, codes and defaults for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ       = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [VALUE_W-1:0]  front_value;
    logic [VALUE_W-1:0]  back_value;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;      // apply the incoming item to the pointers and the store
    logic load_imm;  // load the result register from this cycle's item
    logic load_rd;   // load the result register from the store read data
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_read; // incoming item is an in-range read
  } sts_t;

endpackage

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue over a circular store: push front/back, indexed read and write.
// Latency: a push, a write or a refused item answers in the cycle after transfer;
// an in-range read passes the registered store read port, then the result register.
// Throughput: one item per cycle if results drain; an in-range read stalls input.
// Reset clears the head pointer, the element count and the result valid flag;
// the element store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);

  import deq_pkg::*;

  // The controller owns the handshakes and the single wait state of a read;
  // the datapath owns the pointers, the store, the cached end elements and
  // the result register. They talk only through cmd and sts.
  cmd_t cmd;
  sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The front and back elements are kept in registers beside the store, so
  // only an in-range read needs a store access before its result is known.
  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

`ifndef SYNTH
  // An in-range read holds off the next transfer for its wait cycle.
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && sts.need_read) |=> !req_ready)
    else $error("transfer taken while a store read is in flight");

  // Every accepted item leaves a result waiting within its latency.
  a_imm_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !sts.need_read) |=> rsp_valid)
    else $error("no result after a push, write or refused item");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && sts.need_read) |=> ##1 rsp_valid)
    else $error("no result two cycles after an in-range read");

  // Results of reads from the store always carry status ok.
  a_read_status: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && sts.need_read) |=> ##1 (rsp.status == ST_OK))
    else $error("in-range read answered with an error status");
`endif

endmodule

// ----- rtl/deq_ram.sv -----
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/deq_ctrl.sv -----
// Controller for the double-ended queue: handshakes and read sequencing.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  deq_pkg::sts_t sts,
  output deq_pkg::cmd_t cmd
);

  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;
  logic accept;

  // A new item may enter in the idle state once the result register is free or being drained.
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.exec     = accept;
    cmd.load_imm = accept && !sts.need_read;
    cmd.load_rd  = (state == S_READ);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && sts.need_read) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_imm || cmd.load_rd) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- rtl/deq_dp.sv -----
// Datapath for the double-ended queue: pointers, element store and result register.
`timescale 1ns / 1ps

module deq_dp #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  deq_pkg::req_t req,
  input  deq_pkg::cmd_t cmd,
  output deq_pkg::sts_t sts,
  output deq_pkg::rsp_t rsp
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [CW-1:0] DEPTH_C      = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT    = AW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_SUM    = (PW + 1)'(DEPTH);

  logic [AW-1:0]         head;
  logic [AW-1:0]         head_next;
  logic [AW-1:0]         head_dec;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [DATA_WIDTH-1:0] front_val;
  logic [DATA_WIDTH-1:0] front_next;
  logic [DATA_WIDTH-1:0] back_val;
  logic [DATA_WIDTH-1:0] back_next;
  logic [DATA_WIDTH-1:0] val;
  logic [63:0]           val_w;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         count_w;
  logic [PW-1:0]         idx;
  logic [PW:0]           sum;
  logic [PW:0]           sum_wrap;
  logic [AW-1:0]         slot;
  logic                  full;
  logic                  in_range;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [STATUS_W-1:0]   status_c;
  logic [DATA_WIDTH-1:0] rdata;
  rsp_t                  rsp_imm;
  rsp_t                  rsp_rd;

  assign val_w    = 64'(req.value);
  assign val      = val_w[DATA_WIDTH-1:0];
  assign pos_w    = PW'(req.position);
  assign count_w  = PW'(count);
  assign full     = (count == DEPTH_C);
  assign in_range = (pos_w < count_w);
  assign head_dec = (head == '0) ? LAST_SLOT : head - 1'b1;

  // Physical slot of a logical index: one add and a single wrap correction,
  // since head and index both stay below the depth.
  assign idx      = (req.kind == KIND_PUSH_BACK) ? count_w : pos_w;
  assign sum      = (PW + 1)'(head) + (PW + 1)'(idx);
  assign sum_wrap = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
  assign slot     = sum_wrap[AW-1:0];

  assign sts.need_read = (req.kind == KIND_READ) && in_range;

  always_comb begin
    head_next  = head;
    count_next = count;
    front_next = front_val;
    back_next  = back_val;
    status_c   = ST_OK;
    we         = 1'b0;
    waddr      = slot;
    unique case (req.kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + 1'b1;
          front_next = val;
          if (count == '0) begin
            back_next = val;
          end
          we    = 1'b1;
          waddr = head_dec;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          count_next = count + 1'b1;
          back_next  = val;
          if (count == '0) begin
            front_next = val;
          end
          we = 1'b1;
        end
      end
      KIND_READ: begin
        if (!in_range) begin
          status_c = ST_RANGE;
        end
      end
      KIND_WRITE: begin
        if (!in_range) begin
          status_c = ST_RANGE;
        end else begin
          we = 1'b1;
          if (pos_w == '0) begin
            front_next = val;
          end
          if (pos_w == count_w - 1'b1) begin
            back_next = val;
          end
        end
      end
    endcase
  end

  always_comb begin
    logic [63:0] fw;
    logic [63:0] bw;
    logic [63:0] rw;
    logic [31:0] cw;
    fw = 64'(front_next);
    bw = 64'(back_next);
    cw = 32'(count_next);
    rsp_imm.read_value  = '0;
    rsp_imm.count       = cw[COUNT_W-1:0];
    rsp_imm.is_empty    = (count_next == '0);
    rsp_imm.front_value = (count_next == '0) ? '0 : fw[VALUE_W-1:0];
    rsp_imm.back_value  = (count_next == '0) ? '0 : bw[VALUE_W-1:0];
    rsp_imm.status      = status_c;

    fw = 64'(front_val);
    bw = 64'(back_val);
    rw = 64'(rdata);
    cw = 32'(count);
    rsp_rd.read_value  = rw[VALUE_W-1:0];
    rsp_rd.count       = cw[COUNT_W-1:0];
    rsp_rd.is_empty    = (count == '0);
    rsp_rd.front_value = (count == '0) ? '0 : fw[VALUE_W-1:0];
    rsp_rd.back_value  = (count == '0) ? '0 : bw[VALUE_W-1:0];
    rsp_rd.status      = ST_OK;
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && we),
    .waddr (waddr),
    .wdata (val),
    .re    (cmd.exec),
    .raddr (slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      front_val <= front_next;
      back_val  <= back_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      rsp <= rsp_imm;
    end else if (cmd.load_rd) begin
      rsp <= rsp_rd;
    end
  end

endmodule
